// ===== sv/epoch_to_local_time_dst_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the epoch to local time converter
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef EPOCH_TO_LOCAL_TIME_DST_ASSERT_SVH
`define EPOCH_TO_LOCAL_TIME_DST_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define E2L_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("e2l assertion failed");
// Next-cycle implication.
`define E2L_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("e2l assertion failed");
`else
`define E2L_ASSERT_IMPL(label, ante, cons)
`define E2L_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/e2l_pkg.sv =====
// ----------------------------------------------------------------------------
// e2l_pkg
// Shared types and constants of the epoch to local time converter.
// ----------------------------------------------------------------------------
package e2l_pkg;

	// Width of the shared compare-subtract unit and its working remainder.
	localparam int ACC_W = 33;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_ZONE = 2'd0;
	localparam logic [1:0] REG_DST  = 2'd1;

	// Days from 1901-01-01 to 1970-01-01, as seconds; makes the time non-negative.
	localparam logic signed [33:0] DAY_BIAS_SEC = 34'sd2177452800;
	localparam logic signed [33:0] DST_SHIFT_SEC = 34'sd3600;

	// Restoring divisions: divisor pre-shifted by (steps - 1).
	localparam logic [ACC_W-1:0] DEN_DAY  = 33'd2831155200; // 86400 << 15
	localparam logic [3:0]       LAST_DAY = 4'd15;
	localparam logic [ACC_W-1:0] DEN_HOUR = 33'd57600;      // 3600 << 4
	localparam logic [3:0]       LAST_HOUR = 4'd4;
	localparam logic [ACC_W-1:0] DEN_MIN  = 33'd1920;       // 60 << 5
	localparam logic [3:0]       LAST_MIN = 4'd5;
	localparam logic [ACC_W-1:0] DEN_WDAY = 33'd28672;      // 7 << 12
	localparam logic [3:0]       LAST_WDAY = 4'd12;
	localparam logic [ACC_W-1:0] DEN_QUAD = 33'd46752;      // 1461 << 5
	localparam logic [3:0]       LAST_QUAD = 4'd5;
	localparam logic [ACC_W-1:0] DEN_MOD7 = 33'd896;        // 7 << 7
	localparam logic [3:0]       LAST_MOD7 = 4'd7;

	// Weekday of the biased day count: (day + 7340036) mod 7 == (biased + 2) mod 7.
	localparam logic [15:0] WDAY_OFFSET = 16'd2;
	localparam logic [ACC_W-1:0] YEAR_DAYS = 33'd365;
	localparam logic [10:0] SUN_BIAS = 11'd700;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] month_day;
		logic [3:0] month;
		logic [7:0] year_since_1900;
		logic [2:0] weekday;
		logic [8:0] year_day;
		logic       dst_active;
	} tm_t;

endpackage

// ===== sv/e2l_csub.sv =====
// ----------------------------------------------------------------------------
// e2l_csub
// Shared compare-subtract unit: difference and a >= b flag.
// ----------------------------------------------------------------------------
module e2l_csub import e2l_pkg::*; (
	input  logic [ACC_W-1:0] a,
	input  logic [ACC_W-1:0] b,
	output logic [ACC_W-1:0] diff,
	output logic             ge
);

	logic [ACC_W:0] wide;

	always_comb begin
		wide = {1'b0, a} - {1'b0, b};
		diff = wide[ACC_W-1:0];
		ge   = ~wide[ACC_W];
	end

endmodule

// ===== sv/e2l_seq.sv =====
// ----------------------------------------------------------------------------
// e2l_seq
// Sequencer that splits local time into calendar fields with one shared
// compare-subtract unit, then redoes the split when daylight saving is in force.
// ----------------------------------------------------------------------------
`include "epoch_to_local_time_dst_assert.svh"

module e2l_seq import e2l_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] epoch,
	input  logic signed [16:0] zone,
	input  logic               dst_en,
	input  logic               take,
	output logic               busy,
	output logic               res_valid,
	output tm_t                res
);

	typedef enum logic [3:0] {
		S_IDLE, S_DAY, S_HOUR, S_MIN, S_WDAY, S_QUAD, S_YEAR, S_MONTH,
		S_BEG, S_END, S_DEC, S_DONE
	} state_t;

	state_t                  state_q;
	logic signed [33:0]      t_q;
	logic [ACC_W-1:0]        acc_q;
	logic [ACC_W-1:0]        den_q;
	logic [15:0]             quo_q;
	logic [3:0]              cnt_q;
	logic [15:0]             dayb_q;
	logic [5:0]              q4_q;
	logic [1:0]              yk_q;
	logic [3:0]              mon_q;
	logic                    leap_q;
	logic                    pass_q;
	logic signed [10:0]      beg_q;
	logic signed [10:0]      end_q;
	tm_t                     res_q;

	logic [ACC_W-1:0]        op_b;
	logic [ACC_W-1:0]        diff;
	logic                    ge;
	logic [15:0]             q_fin;
	logic [ACC_W-1:0]        r_fin;
	logic signed [33:0]      t_start;
	logic signed [33:0]      t_shift;
	logic [33:0]             tb_start;
	logic [33:0]             tb_shift;
	logic [8:0]              bd_beg;
	logic [8:0]              bd_end;
	logic [10:0]             num_beg;
	logic [10:0]             num_end;
	logic signed [10:0]      dayno;
	logic [4:0]              end_hour;
	logic                    in_win;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd1:                      len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// Shift a day on or after the end of February by one in leap years.
	function automatic logic [8:0] leap_adj(input logic [8:0] d, input logic leap);
		return (d >= 9'd58) ? d + {8'd0, leap} : d;
	endfunction

	always_comb begin
		unique case (state_q)
			S_YEAR:  op_b = YEAR_DAYS;
			S_MONTH: op_b = {28'd0, month_len(mon_q, leap_q)};
			default: op_b = den_q;
		endcase
	end

	e2l_csub u_csub (
		.a    (acc_q),
		.b    (op_b),
		.diff (diff),
		.ge   (ge)
	);

	always_comb begin
		q_fin = {quo_q[14:0], ge};
		r_fin = ge ? diff : acc_q;

		t_start  = $signed({{2{epoch[31]}}, epoch}) - $signed({{17{zone[16]}}, zone});
		t_shift  = t_q + DST_SHIFT_SEC;
		tb_start = t_start + DAY_BIAS_SEC;
		tb_shift = t_shift + DAY_BIAS_SEC;

		// Daylight window bounds in standard local time of pass one.
		if (res_q.year_since_1900 == 8'd74) begin
			bd_beg = leap_adj(9'd5, leap_q);
			bd_end = leap_adj(9'd333, leap_q);
		end else if (res_q.year_since_1900 == 8'd75) begin
			bd_beg = leap_adj(9'd58, leap_q);
			bd_end = leap_adj(9'd303, leap_q);
		end else begin
			bd_beg = leap_adj(9'd119, leap_q);
			bd_end = leap_adj(9'd303, leap_q);
		end
		num_beg = {2'd0, bd_beg} + {8'd0, res_q.weekday} + SUN_BIAS
			- {2'd0, res_q.year_day};
		num_end = {2'd0, bd_end} + {8'd0, res_q.weekday} + SUN_BIAS
			- {2'd0, res_q.year_day};

		dayno    = $signed({2'd0, res_q.year_day});
		end_hour = (res_q.year_since_1900 == 8'd88) ? 5'd2 : 5'd1;
		in_win   = ((dayno > beg_q) || (dayno == beg_q && res_q.hour >= 5'd2)) &&
			((dayno < end_q) || (dayno == end_q && res_q.hour < end_hour));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= 1'b0;
		end else begin
			unique case (state_q) inside
				S_IDLE: begin
					if (start) begin
						t_q              <= t_start;
						acc_q            <= tb_start[ACC_W-1:0];
						den_q            <= DEN_DAY;
						cnt_q            <= LAST_DAY;
						quo_q            <= '0;
						pass_q           <= 1'b0;
						res_q.dst_active <= 1'b0;
						state_q          <= S_DAY;
					end
				end
				S_DAY, S_HOUR, S_MIN, S_WDAY, S_QUAD, S_BEG, S_END: begin
					if (cnt_q != 4'd0) begin
						// One restoring division step.
						if (ge) begin
							acc_q <= diff;
						end
						quo_q <= q_fin;
						den_q <= den_q >> 1;
						cnt_q <= cnt_q - 4'd1;
					end else begin
						// Last step: hand quotient and remainder on.
						quo_q <= '0;
						unique case (state_q)
							S_DAY: begin
								dayb_q  <= q_fin;
								acc_q   <= {16'd0, r_fin[16:0]};
								den_q   <= DEN_HOUR;
								cnt_q   <= LAST_HOUR;
								state_q <= S_HOUR;
							end
							S_HOUR: begin
								res_q.hour <= q_fin[4:0];
								acc_q      <= r_fin;
								den_q      <= DEN_MIN;
								cnt_q      <= LAST_MIN;
								state_q    <= S_MIN;
							end
							S_MIN: begin
								res_q.minute <= q_fin[5:0];
								res_q.second <= r_fin[5:0];
								acc_q        <= {17'd0, dayb_q + WDAY_OFFSET};
								den_q        <= DEN_WDAY;
								cnt_q        <= LAST_WDAY;
								state_q      <= S_WDAY;
							end
							S_WDAY: begin
								res_q.weekday <= r_fin[2:0];
								acc_q         <= {17'd0, dayb_q};
								den_q         <= DEN_QUAD;
								cnt_q         <= LAST_QUAD;
								state_q       <= S_QUAD;
							end
							S_QUAD: begin
								q4_q    <= q_fin[5:0];
								acc_q   <= r_fin;
								yk_q    <= 2'd0;
								state_q <= S_YEAR;
							end
							S_BEG: begin
								beg_q   <= $signed({2'd0, bd_beg}) - $signed({8'd0, r_fin[2:0]});
								acc_q   <= {22'd0, num_end};
								den_q   <= DEN_MOD7;
								cnt_q   <= LAST_MOD7;
								state_q <= S_END;
							end
							default: begin
								end_q   <= $signed({2'd0, bd_end}) - $signed({8'd0, r_fin[2:0]});
								state_q <= S_DEC;
							end
						endcase
					end
				end
				S_YEAR: begin
					// Peel whole years off the four-year cycle.
					if (ge && yk_q != 2'd3) begin
						acc_q <= diff;
						yk_q  <= yk_q + 2'd1;
					end else begin
						res_q.year_since_1900 <= 8'd1 + {q4_q, 2'b00} + {6'd0, yk_q};
						res_q.year_day        <= acc_q[8:0];
						leap_q                <= (yk_q == 2'd3);
						mon_q                 <= 4'd0;
						state_q               <= S_MONTH;
					end
				end
				S_MONTH: begin
					if (ge && mon_q != 4'd11) begin
						acc_q <= diff;
						mon_q <= mon_q + 4'd1;
					end else begin
						res_q.month_day <= acc_q[4:0] + 5'd1;
						res_q.month     <= mon_q;
						if (pass_q) begin
							res_q.dst_active <= 1'b1;
							state_q          <= S_DONE;
						end else begin
							acc_q   <= {22'd0, num_beg};
							den_q   <= DEN_MOD7;
							cnt_q   <= LAST_MOD7;
							state_q <= S_BEG;
						end
					end
				end
				S_DEC: begin
					if (dst_en && in_win) begin
						// Add the daylight hour and split again.
						t_q     <= t_shift;
						acc_q   <= tb_shift[ACC_W-1:0];
						den_q   <= DEN_DAY;
						cnt_q   <= LAST_DAY;
						pass_q  <= 1'b1;
						state_q <= S_DAY;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	`E2L_ASSERT_NEXT(a_start_runs, start && state_q == S_IDLE, state_q == S_DAY)
	`E2L_ASSERT_IMPL(a_done_ranges, state_q == S_DONE, res_q.hour < 5'd24 && res_q.minute < 6'd60 && res_q.second < 6'd60 && res_q.month < 4'd12 && res_q.month_day != 5'd0)
	`E2L_ASSERT_IMPL(a_month_rem, state_q == S_MONTH, acc_q < 33'd366)
	`E2L_ASSERT_NEXT(a_dec_exit, state_q == S_DEC, state_q == S_DONE || state_q == S_DAY)

endmodule

// ===== sv/epoch_to_local_time_dst.sv =====
// ----------------------------------------------------------------------------
// epoch_to_local_time_dst
// Converts signed seconds since 1970 GMT into local broken-down time with
// an optional daylight saving hour.
// ----------------------------------------------------------------------------
// Conversion time is set by the single compare-subtract unit that runs every
// division step and every year and month step in turn, with a second split
// for the daylight hour. in_stall is high while busy; no word is taken then.
// A finished word waits in the output register, so a new word is taken meanwhile.
// Reset: zone offset 28800, daylight rule on, no result pending.
// ----------------------------------------------------------------------------
module epoch_to_local_time_dst import e2l_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	// input word
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] epoch_seconds,
	// output word
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         second,
	output logic [5:0]         minute,
	output logic [4:0]         hour,
	output logic [4:0]         month_day,
	output logic [3:0]         month,
	output logic [7:0]         year_since_1900,
	output logic [2:0]         weekday,
	output logic [8:0]         year_day,
	output logic               dst_active
);

	logic signed [16:0] zone_q;
	logic               dst_en_q;
	logic               out_valid_q;
	tm_t                out_q;

	logic               busy;
	logic               res_valid;
	tm_t                res;
	logic               take;
	logic               start;

	// Configuration registers; writes beyond the register list drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q   <= 17'sd28800;
			dst_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ZONE: zone_q   <= $signed(cfg_data);
				REG_DST:  dst_en_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	// Accept a word only while the sequencer is idle.
	assign in_stall = busy;
	assign start    = in_valid && !busy;

	// Move the finished word into the output register once it is free.
	assign take = res_valid && (!out_valid_q || !out_stall);

	e2l_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.epoch     (epoch_seconds),
		.zone      (zone_q),
		.dst_en    (dst_en_q),
		.take      (take),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: hold while stalled, load on take, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign second          = out_q.second;
	assign minute          = out_q.minute;
	assign hour            = out_q.hour;
	assign month_day       = out_q.month_day;
	assign month           = out_q.month;
	assign year_since_1900 = out_q.year_since_1900;
	assign weekday         = out_q.weekday;
	assign year_day        = out_q.year_day;
	assign dst_active      = out_q.dst_active;

endmodule
